### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every property is clocked on the rising
// edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lbsc_pkg.sv
package lbsc_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = SLOT_W + 1;

    localparam logic [7:0]  EMPTY_ID       = 8'hFF;
    localparam logic [15:0] MAX_BANK_BYTES = 16'd32768;

    localparam logic [1:0] MODE_ACCESS = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_BANK_BYTES   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } lbsc_state_t;

    // Write request into the slot store.
    typedef struct packed {
        logic              clear;
        logic              en;
        logic              set_bank;
        logic [SLOT_W-1:0] addr;
        logic [7:0]        bank;
        logic [31:0]       stamp;
    } lbsc_slot_wr_t;

    // Contents of the slot selected by the read address.
    typedef struct packed {
        logic        valid;
        logic [7:0]  bank;
        logic [31:0] stamp;
    } lbsc_slot_rd_t;

endpackage

### hw/rtl/lbsc_slot_store.sv
module lbsc_slot_store
    import lbsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lbsc_slot_wr_t     wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output lbsc_slot_rd_t     rd
);

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [7:0]           bank_id_reg [NUM_SLOTS];
    logic [31:0]          stamp_reg   [NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.clear) begin
            valid_reg <= '0;
        end else if (wr.en && wr.set_bank) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Bank ids and stamps of empty slots are never used, so they carry no reset.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            stamp_reg[wr.addr] <= wr.stamp;
            if (wr.set_bank) begin
                bank_id_reg[wr.addr] <= wr.bank;
            end
        end
    end

    assign rd.valid = valid_reg[rd_addr];
    assign rd.bank  = valid_reg[rd_addr] ? bank_id_reg[rd_addr] : EMPTY_ID;
    assign rd.stamp = stamp_reg[rd_addr];

endmodule

### hw/rtl/lru_bank_slot_cache_top.sv
// Fully associative cache of ROM bank slots with least-recently-used
// replacement by 32-bit timestamps. An access transaction is accepted, walks
// the slots one per cycle with a single compare unit (bank match, first empty
// slot, least stamp), then updates the slot and registers the result. A miss
// walks every slot in use; a hit stops the walk at the matching slot.
// Invalidate and query transactions skip the walk. A new transaction is
// accepted only once the previous one has been placed in the output register;
// a result may wait there for m_ready while the next transaction is accepted.
// On a miss the fetch offset is bank_id times the bank size in bytes, with the
// bank size limited to 32768. Configuration writes take effect at once and must
// only be issued while the block is idle.
`include "assert_macros.svh"

module lru_bank_slot_cache_top
    import lbsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_bank_id,
    input  logic        s_rom_kind,
    input  logic [2:0]  s_slot_select,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_slot,
    output logic        m_hit,
    output logic        m_fetch,
    output logic        m_fetch_rom,
    output logic [22:0] m_fetch_offset,
    output logic [7:0]  m_slot_bank
);

    lbsc_state_t state_reg, state_next;

    logic [3:0]        slots_cfg_reg;
    logic [15:0]       bank_bytes_reg;
    logic [31:0]       tick_reg, tick_next;
    logic [1:0]        mode_reg, mode_next;
    logic [7:0]        bank_reg, bank_next;
    logic              rom_reg, rom_next;
    logic [2:0]        sel_reg, sel_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              hit_reg, hit_next;
    logic              inv_reg, inv_next;
    logic [SLOT_W-1:0] cand_reg, cand_next;
    logic [31:0]       min_reg, min_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_slot_reg, m_slot_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_fetch_reg, m_fetch_next;
    logic              m_fetch_rom_reg, m_fetch_rom_next;
    logic [22:0]       m_fetch_offset_reg, m_fetch_offset_next;
    logic [7:0]        m_slot_bank_reg, m_slot_bank_next;

    logic [CNT_W-1:0]  n_eff;
    logic              last_slot;
    logic [15:0]       size_eff;
    logic [23:0]       offset_full;
    logic              out_free;

    lbsc_slot_wr_t     wr;
    lbsc_slot_rd_t     rd;

    lbsc_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (idx_reg),
        .rd      (rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_cfg_reg  <= 4'd8;
            bank_bytes_reg <= 16'd8192;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SLOTS_IN_USE: slots_cfg_reg  <= cfg_data[3:0];
                CFG_BANK_BYTES:   bank_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (slots_cfg_reg == 4'd0) begin
            n_eff = CNT_W'(1);
        end else if (32'(slots_cfg_reg) > NUM_SLOTS) begin
            n_eff = CNT_W'(NUM_SLOTS);
        end else begin
            n_eff = CNT_W'(slots_cfg_reg);
        end
    end

    assign last_slot   = ({1'b0, idx_reg} + CNT_W'(1)) == n_eff;
    assign size_eff    = (bank_bytes_reg > MAX_BANK_BYTES) ? MAX_BANK_BYTES : bank_bytes_reg;
    assign offset_full = 24'(bank_reg) * 24'(size_eff);
    assign out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg           <= mode_next;
        bank_reg           <= bank_next;
        rom_reg            <= rom_next;
        sel_reg            <= sel_next;
        idx_reg            <= idx_next;
        hit_reg            <= hit_next;
        inv_reg            <= inv_next;
        cand_reg           <= cand_next;
        min_reg            <= min_next;
        m_slot_reg         <= m_slot_next;
        m_hit_reg          <= m_hit_next;
        m_fetch_reg        <= m_fetch_next;
        m_fetch_rom_reg    <= m_fetch_rom_next;
        m_fetch_offset_reg <= m_fetch_offset_next;
        m_slot_bank_reg    <= m_slot_bank_next;
    end

    always_comb begin
        state_next          = state_reg;
        tick_next           = tick_reg;
        mode_next           = mode_reg;
        bank_next           = bank_reg;
        rom_next            = rom_reg;
        sel_next            = sel_reg;
        idx_next            = idx_reg;
        hit_next            = hit_reg;
        inv_next            = inv_reg;
        cand_next           = cand_reg;
        min_next            = min_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_slot_next         = m_slot_reg;
        m_hit_next          = m_hit_reg;
        m_fetch_next        = m_fetch_reg;
        m_fetch_rom_next    = m_fetch_rom_reg;
        m_fetch_offset_next = m_fetch_offset_reg;
        m_slot_bank_next    = m_slot_bank_reg;
        s_ready             = 1'b0;
        wr                  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next  = s_mode;
                    bank_next  = s_bank_id;
                    rom_next   = s_rom_kind;
                    sel_next   = s_slot_select;
                    hit_next   = 1'b0;
                    inv_next   = 1'b0;
                    cand_next  = '0;
                    state_next = ST_RESP;
                    unique case (s_mode)
                        MODE_ACCESS: begin
                            tick_next  = tick_reg + 32'd1;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        MODE_CLEAR: begin
                            tick_next = '0;
                            wr.clear  = 1'b1;
                        end
                        MODE_QUERY: begin
                            idx_next = SLOT_W'(s_slot_select);
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                // One slot per cycle: a match ends the walk, otherwise the first
                // empty slot wins over the least stamp (lowest index on a tie).
                if (rd.valid && rd.bank == bank_reg) begin
                    hit_next   = 1'b1;
                    cand_next  = idx_reg;
                    state_next = ST_RESP;
                end else begin
                    if (!rd.valid && !inv_reg) begin
                        inv_next  = 1'b1;
                        cand_next = idx_reg;
                    end else if (rd.valid && !inv_reg &&
                                 (idx_reg == '0 || rd.stamp < min_reg)) begin
                        cand_next = idx_reg;
                        min_next  = rd.stamp;
                    end
                    if (last_slot) begin
                        state_next = ST_RESP;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_slot_next         = '0;
                    m_hit_next          = 1'b0;
                    m_fetch_next        = 1'b0;
                    m_fetch_rom_next    = 1'b0;
                    m_fetch_offset_next = '0;
                    m_slot_bank_next    = '0;
                    state_next          = ST_IDLE;
                    unique case (mode_reg)
                        MODE_ACCESS: begin
                            wr.en       = 1'b1;
                            wr.set_bank = !hit_reg;
                            wr.addr     = cand_reg;
                            wr.bank     = bank_reg;
                            wr.stamp    = tick_reg;
                            m_slot_next      = 3'(cand_reg);
                            m_hit_next       = hit_reg;
                            m_fetch_next     = !hit_reg;
                            m_slot_bank_next = bank_reg;
                            if (!hit_reg) begin
                                m_fetch_rom_next    = rom_reg;
                                m_fetch_offset_next = offset_full[22:0];
                            end
                        end
                        MODE_QUERY: begin
                            m_slot_next = sel_reg;
                            if (32'(sel_reg) < 32'(n_eff)) begin
                                m_slot_bank_next = rd.bank;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_slot         = m_slot_reg;
    assign m_hit          = m_hit_reg;
    assign m_fetch        = m_fetch_reg;
    assign m_fetch_rom    = m_fetch_rom_reg;
    assign m_fetch_offset = m_fetch_offset_reg;
    assign m_slot_bank    = m_slot_bank_reg;

    `ASSERT_IMPLY(a_hit_xor_fetch, aclk, aresetn, m_valid, !(m_hit && m_fetch), "hit and fetch both set")
    `ASSERT_IMPLY(a_hit_no_fetch_data, aclk, aresetn, m_valid && m_hit, m_fetch_offset == '0 && !m_fetch_rom, "fetch data on a hit")
    `ASSERT_IMPLY(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, CNT_W'(idx_reg) < n_eff, "scan index beyond slots in use")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after an accepted transaction")

endmodule

### tb/sv/lru_bank_slot_cache_top_tb.sv
`timescale 1ns / 1ps

module lru_bank_slot_cache_top_tb
    import lbsc_pkg::*;
();

    // The fourth mode value has no meaning and must leave the cache untouched.
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] bank_id;
        logic       rom_kind;
        logic [2:0] slot_select;
    } cache_cmd_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic        hit;
        logic        fetch;
        logic        fetch_rom;
        logic [22:0] fetch_offset;
        logic [7:0]  slot_bank;
    } cache_resp_t;

    typedef struct packed {
        cache_cmd_t  cmd;
        logic        typed;
        cache_resp_t resp;
    } script_row_t;

    localparam cache_resp_t ZERO_RESP = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_bank_id;
    logic        s_rom_kind;
    logic [2:0]  s_slot_select;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_slot;
    logic        m_hit;
    logic        m_fetch;
    logic        m_fetch_rom;
    logic [22:0] m_fetch_offset;
    logic [7:0]  m_slot_bank;

    // Shadow copy of the slot store, the use tick and the two registers.
    logic [7:0]  bank_tag [NUM_SLOTS];
    logic        tag_valid [NUM_SLOTS];
    logic [31:0] tag_stamp [NUM_SLOTS];
    logic [31:0] lru_tick;
    logic [3:0]  cfg_slots = 4'd8;
    logic [15:0] cfg_bank_bytes = 16'd8192;

    cache_resp_t pending_resp [$];

    bit steady = 1'b0;
    bit stall_req = 1'b0;
    int fault_count = 0;
    int results_seen = 0;
    int hits = 0;
    int fetches = 0;
    int n_access = 0;
    int n_query = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_stalls = 0;

    logic [15:0] phase_slots [PHASES] = '{16'd8, 16'd1, 16'd0, 16'd15,
                                          16'd3, 16'd8, 16'h0C35, 16'd8};
    logic [15:0] phase_size [PHASES] = '{16'd32768, 16'd1024, 16'hFFFF, 16'd40000,
                                         16'd1, 16'd0, 16'd4096, 16'd8192};

    script_row_t directed_rows [23] = '{
        // Fresh cache: slots 0 and 7 read back empty.
        '{'{MODE_QUERY,  8'd0,   1'b0, 3'd0}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 23'd0, EMPTY_ID}},
        '{'{MODE_QUERY,  8'd255, 1'b1, 3'd7}, 1'b1, '{3'd7, 1'b0, 1'b0, 1'b0, 23'd0, EMPTY_ID}},
        '{'{MODE_NONE,   8'd255, 1'b1, 3'd7}, 1'b1, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd0,   1'b0, 3'd0}, 1'b1, '{3'd0, 1'b0, 1'b1, 1'b0, 23'd0, 8'd0}},
        // Bank 255 must miss even though empty slots carry that id.
        '{'{MODE_ACCESS, 8'd255, 1'b1, 3'd0}, 1'b1,
          '{3'd1, 1'b0, 1'b1, 1'b1, 23'd2088960, 8'd255}},
        '{'{MODE_ACCESS, 8'd255, 1'b0, 3'd3}, 1'b1, '{3'd1, 1'b1, 1'b0, 1'b0, 23'd0, 8'd255}},
        '{'{MODE_ACCESS, 8'd0,   1'b1, 3'd6}, 1'b1, '{3'd0, 1'b1, 1'b0, 1'b0, 23'd0, 8'd0}},
        '{'{MODE_ACCESS, 8'd1,   1'b0, 3'd1}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd2,   1'b1, 3'd2}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd3,   1'b0, 3'd3}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd4,   1'b1, 3'd4}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd5,   1'b0, 3'd5}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd6,   1'b1, 3'd6}, 1'b0, ZERO_RESP},
        // All slots full: the next misses evict the least recently used.
        '{'{MODE_ACCESS, 8'd7,   1'b0, 3'd7}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'd255, 1'b1, 3'd0}, 1'b0, ZERO_RESP},
        '{'{MODE_QUERY,  8'd9,   1'b0, 3'd3}, 1'b0, ZERO_RESP},
        '{'{MODE_CLEAR,  8'hAA,  1'b1, 3'd5}, 1'b1, ZERO_RESP},
        '{'{MODE_QUERY,  8'd0,   1'b0, 3'd1}, 1'b1, '{3'd1, 1'b0, 1'b0, 1'b0, 23'd0, EMPTY_ID}},
        '{'{MODE_ACCESS, 8'd128, 1'b1, 3'd4}, 1'b1,
          '{3'd0, 1'b0, 1'b1, 1'b1, 23'd1048576, 8'd128}},
        '{'{MODE_ACCESS, 8'h55,  1'b0, 3'd2}, 1'b0, ZERO_RESP},
        '{'{MODE_ACCESS, 8'hAA,  1'b1, 3'd5}, 1'b0, ZERO_RESP},
        '{'{MODE_NONE,   8'h55,  1'b0, 3'd5}, 1'b1, ZERO_RESP},
        '{'{MODE_QUERY,  8'hFF,  1'b1, 3'd2}, 1'b0, ZERO_RESP}
    };

    lru_bank_slot_cache_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_bank_id      (s_bank_id),
        .s_rom_kind     (s_rom_kind),
        .s_slot_select  (s_slot_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot         (m_slot),
        .m_hit          (m_hit),
        .m_fetch        (m_fetch),
        .m_fetch_rom    (m_fetch_rom),
        .m_fetch_offset (m_fetch_offset),
        .m_slot_bank    (m_slot_bank)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_slot_tags();
        int k;
        for (k = 0; k < NUM_SLOTS; k++) begin
            bank_tag[k] = EMPTY_ID;
            tag_valid[k] = 1'b0;
            tag_stamp[k] = 32'd0;
        end
        lru_tick = 32'd0;
    endfunction

    function automatic cache_resp_t predict_slot_lookup(cache_cmd_t c);
        cache_resp_t r;
        int n;
        int k;
        int victim;
        logic [15:0] sz;
        logic [31:0] product;
        r = '0;
        victim = -1;
        n = int'(cfg_slots);
        if (n < 1) n = 1;
        if (n > NUM_SLOTS) n = NUM_SLOTS;
        case (c.mode)
            MODE_ACCESS: begin
                lru_tick = lru_tick + 32'd1;
                for (k = 0; k < n; k++) begin
                    if (victim < 0 && tag_valid[k] && bank_tag[k] == c.bank_id) victim = k;
                end
                if (victim >= 0) begin
                    tag_stamp[victim] = lru_tick;
                    r.slot = 3'(victim);
                    r.hit = 1'b1;
                    r.slot_bank = c.bank_id;
                end else begin
                    for (k = 0; k < n; k++) begin
                        if (victim < 0 && !tag_valid[k]) victim = k;
                    end
                    // No empty slot: the oldest stamp loses, ties go to the lower slot.
                    if (victim < 0) begin
                        victim = 0;
                        for (k = 1; k < n; k++) begin
                            if (tag_stamp[k] < tag_stamp[victim]) victim = k;
                        end
                    end
                    sz = (cfg_bank_bytes > MAX_BANK_BYTES) ? MAX_BANK_BYTES : cfg_bank_bytes;
                    product = 32'(c.bank_id) * 32'(sz);
                    bank_tag[victim] = c.bank_id;
                    tag_valid[victim] = 1'b1;
                    tag_stamp[victim] = lru_tick;
                    r.slot = 3'(victim);
                    r.fetch = 1'b1;
                    r.fetch_rom = c.rom_kind;
                    r.fetch_offset = product[22:0];
                    r.slot_bank = c.bank_id;
                end
            end
            MODE_CLEAR: clear_slot_tags();
            MODE_QUERY: begin
                r.slot = c.slot_select;
                if (int'(c.slot_select) < n) r.slot_bank = bank_tag[c.slot_select];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Starts and ends at a falling edge. Valid stays high afterwards; the caller
    // drops it when no transaction follows.
    task automatic offer_cmd(input cache_cmd_t c, input logic typed, input cache_resp_t fixed);
        int gap;
        cache_resp_t r;
        gap = (!steady && $urandom_range(0, 99) < 17) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= c.mode;
        s_bank_id <= c.bank_id;
        s_rom_kind <= c.rom_kind;
        s_slot_select <= c.slot_select;
        do @(posedge aclk); while (!s_ready);
        r = predict_slot_lookup(c);
        pending_resp.push_back(typed ? fixed : r);
        if (c.mode == MODE_ACCESS) n_access++;
        else if (c.mode == MODE_QUERY) n_query++;
        else if (c.mode == MODE_CLEAR) n_clear++;
        else n_unused++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending_resp.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // Both registers are written on consecutive cycles while nothing is in flight.
    task automatic cfg_apply(input logic [15:0] slots_data, input logic [15:0] size_data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SLOTS_IN_USE;
        cfg_data <= slots_data;
        @(negedge aclk);
        cfg_index <= CFG_BANK_BYTES;
        cfg_data <= size_data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_slots = slots_data[3:0];
        cfg_bank_bytes = size_data;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_req = 1'b0;
                n_stalls++;
            end
            m_ready <= (!steady && $urandom_range(0, 99) < 17) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge aclk) begin
        cache_resp_t got;
        cache_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_slot, m_hit, m_fetch, m_fetch_rom, m_fetch_offset, m_slot_bank};
            results_seen++;
            if (got.hit) hits++;
            if (got.fetch) fetches++;
            if (pending_resp.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: slot=%0d hit=%0b fetch=%0b rom=%0b offset=%0d bank=%0d",
                             got.slot, got.hit, got.fetch, got.fetch_rom, got.fetch_offset,
                             got.slot_bank);
            end else begin
                want = pending_resp.pop_front();
                if (got.slot !== want.slot || got.hit !== want.hit || got.fetch !== want.fetch ||
                    got.fetch_rom !== want.fetch_rom || got.fetch_offset !== want.fetch_offset ||
                    got.slot_bank !== want.slot_bank) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"result %0d mismatch: expected slot=%0d hit=%0b fetch=%0b rom=%0b",
                                  " offset=%0d bank=%0d, got slot=%0d hit=%0b fetch=%0b rom=%0b",
                                  " offset=%0d bank=%0d"},
                                 results_seen, want.slot, want.hit, want.fetch, want.fetch_rom,
                                 want.fetch_offset, want.slot_bank, got.slot, got.hit, got.fetch,
                                 got.fetch_rom, got.fetch_offset, got.slot_bank);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("lru_bank_slot_cache_top_tb: errors");
        $finish;
    end

    initial begin
        int i;
        int p;
        int roll;
        cache_cmd_t c;
        logic [7:0] bank_pool [$];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SLOTS_IN_USE;
        cfg_data = 16'd0;
        s_valid = 1'b0;
        s_mode = MODE_ACCESS;
        s_bank_id = 8'd0;
        s_rom_kind = 1'b0;
        s_slot_select = 3'd0;
        clear_slot_tags();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < 23; i++)
            offer_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].resp);
        s_valid <= 1'b0;
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            cfg_apply(phase_slots[p], phase_size[p]);
            steady = (p == 6);
            // A small working set of banks per phase so that hits and evictions both occur.
            bank_pool.delete();
            repeat ($urandom_range(2, 10)) bank_pool.push_back(8'($urandom_range(0, 255)));
            bank_pool[0] = (p % 2) ? 8'hFF : 8'h00;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (p == PHASES - 1 && i == 20) stall_req = 1'b1;
                c.bank_id = 8'($urandom_range(0, 255));
                c.rom_kind = 1'($urandom_range(0, 1));
                c.slot_select = 3'($urandom_range(0, 7));
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    c.mode = MODE_ACCESS;
                    if ($urandom_range(0, 9) < 8)
                        c.bank_id = bank_pool[$urandom_range(0, bank_pool.size() - 1)];
                end else if (roll < 73) begin
                    c.mode = MODE_CLEAR;
                end else if (roll < 95) begin
                    c.mode = MODE_QUERY;
                end else begin
                    c.mode = MODE_NONE;
                end
                offer_cmd(c, 1'b0, ZERO_RESP);
            end
            s_valid <= 1'b0;
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (pending_resp.size() != 0) begin
            fault_count += pending_resp.size();
            $display("%0d expected results never arrived", pending_resp.size());
        end
        $display("run covered %0d accesses (%0d hits, %0d fetches), %0d queries, %0d clears",
                 n_access, hits, fetches, n_query, n_clear);
        $display("plus %0d unused-mode commands over %0d register settings, %0d long output stalls",
                 n_unused, PHASES + 1, n_stalls);
        if (fault_count == 0) begin
            $display("lru_bank_slot_cache_top_tb: clean");
        end else begin
            $display("lru_bank_slot_cache_top_tb: errors");
        end
        $finish;
    end

endmodule
